// ===== rtl/lwfa_pkg.sv =====
`default_nettype none

package lwfa_pkg;

    localparam int DEFAULT_MAX_LEDS = 32;

    localparam int LEN_W      = 6;
    localparam int HUE_W      = 9;
    localparam int CH_W       = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_DATA_W = 40;
    localparam int FADE_STEP  = 5;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WIPE    = 2'd1,
        OP_FADE    = 2'd2,
        OP_REFRESH = 2'd3
    } op_t;

    localparam logic [1:0] AS_WAITING = 2'd0;
    localparam logic [1:0] AS_UPDATED = 2'd1;
    localparam logic [1:0] AS_DONE    = 2'd2;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_WIPE = 2'd1;
    localparam logic [1:0] MODE_FADE = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HUE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_SAT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIPE_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIPE_LAST  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_COUNT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIP_LEN  = 3'd7;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } pixel_t;

    typedef struct packed {
        logic take_item;
        logic execute;
        logic idx_clear;
        logic idx_step;
        logic mem_read;
        logic fade_write;
        logic fade_finish;
        logic emit_status;
        logic emit_pixel;
    } lwfa_cmd_t;

    typedef struct packed {
        op_t  op;
        logic fade_step;
        logic fade_done;
        logic stream_end;
        logic out_free;
        logic changed;
    } lwfa_stat_t;

    typedef logic [255:0][CH_W-1:0] gamma_rom_t;

    // Entry v counts the rounding thresholds k + 0.5 that 255 * (v / 255)^2.2 reaches, using the exact
    // integer test 32 * v^11 >= (2k + 1)^5 * 255^6.
    function automatic gamma_rom_t build_gamma();
        gamma_rom_t   rom;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] odd;
        int           n;
        logic         stop;
        n = 0;
        for (int v = 0; v < 256; v++)
        begin
            lhs = 128'd32;
            for (int t = 0; t < 11; t++)
            begin
                lhs = lhs * 128'(v);
            end
            stop = 1'b0;
            while (n < 255 && !stop)
            begin
                odd = 128'(2 * n + 1);
                rhs = 128'd1;
                for (int t = 0; t < 5; t++)
                begin
                    rhs = rhs * odd;
                end
                for (int t = 0; t < 6; t++)
                begin
                    rhs = rhs * 128'd255;
                end
                if (lhs >= rhs)
                begin
                    n++;
                end
                else
                begin
                    stop = 1'b1;
                end
            end
            rom[v] = 8'(n);
        end
        return rom;
    endfunction

    localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

`default_nettype wire

// ===== rtl/lwfa_ctrl.sv =====
`default_nettype none

module lwfa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  lwfa_pkg::lwfa_stat_t   stat,
    output lwfa_pkg::lwfa_cmd_t    cmd
);
    import lwfa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EXEC    = 7'b0000010,
        S_FADE_RD = 7'b0000100,
        S_FADE_WR = 7'b0001000,
        S_STATUS  = 7'b0010000,
        S_STR_RD  = 7'b0100000,
        S_STR_OUT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute   = 1'b1;
                cmd.idx_clear = 1'b1;
                if (stat.op == OP_REFRESH)
                begin
                    state_next = S_STR_RD;
                end
                else if (stat.fade_step)
                begin
                    state_next = S_FADE_RD;
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end
            S_FADE_RD:
            begin
                if (stat.fade_done)
                begin
                    cmd.fade_finish = 1'b1;
                    state_next      = S_STATUS;
                end
                else
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = S_FADE_WR;
                end
            end
            S_FADE_WR:
            begin
                cmd.fade_write = 1'b1;
                cmd.idx_step   = 1'b1;
                state_next     = S_FADE_RD;
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.idx_clear   = 1'b1;
                    state_next      = stat.changed ? S_STR_RD : S_IDLE;
                end
            end
            S_STR_RD:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_STR_OUT;
            end
            S_STR_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_pixel = 1'b1;
                    cmd.idx_step   = 1'b1;
                    state_next     = stat.stream_end ? S_IDLE : S_STR_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lwfa_datapath.sv =====
`default_nettype none

module lwfa_datapath #(
    parameter int MAX_LEDS = lwfa_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lwfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lwfa_pkg::CFG_W-1:0]          cfg_data,
    input  logic [lwfa_pkg::TIME_W-1:0]         s_tdata,
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lwfa_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  lwfa_pkg::lwfa_cmd_t                 cmd,
    output lwfa_pkg::lwfa_stat_t                stat
);
    import lwfa_pkg::*;

    localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    // Configuration registers.
    logic [HUE_W-1:0]  cfg_hue_reg;
    logic [CH_W-1:0]   cfg_sat_reg;
    logic [CH_W-1:0]   cfg_val_reg;
    logic [CH_W-1:0]   cfg_first_reg;
    logic [CH_W-1:0]   cfg_last_reg;
    logic [CH_W-1:0]   cfg_count_reg;
    logic [TIME_W-1:0] cfg_interval_reg;
    logic [LEN_W-1:0]  cfg_len_reg;

    // Current item.
    op_t               op_reg;
    logic [TIME_W-1:0] now_reg;

    // Animation state.
    logic [1:0]        mode_reg,      mode_next;
    logic [1:0]        run_status_reg, run_status_next;
    logic [TIME_W-1:0] last_step_reg, last_step_next;
    logic signed [7:0] pos_reg,       pos_next;
    logic signed [7:0] end_reg,       end_next;
    logic              down_reg,      down_next;
    logic [HUE_W-1:0]  run_hue_reg,   run_hue_next;
    logic [CH_W-1:0]   run_sat_reg,   run_sat_next;
    logic [CH_W-1:0]   run_val_reg,   run_val_next;
    logic [TIME_W-1:0] run_interval_reg, run_interval_next;
    logic [LEN_W-1:0]  run_count_reg, run_count_next;
    logic [LEN_W-1:0]  idx_reg,       idx_next;
    logic              changed_reg,   changed_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic              res_last_reg,  res_last_next;

    // Frame store.
    pixel_t            mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    pixel_t            rd_data_reg;
    logic              rd_valid_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    pixel_t            mem_wdata;

    // Output register.
    logic              out_valid_reg;
    logic              out_kind_reg;
    logic [1:0]        out_status_reg;
    logic [LEN_W-1:0]  out_index_reg;
    logic [HUE_W-1:0]  out_hue_reg;
    logic [CH_W-1:0]   out_sat_reg;
    logic [CH_W-1:0]   out_level_reg;
    logic              out_last_reg;

    logic [LEN_W-1:0]  len_eff;
    logic signed [7:0] len_s;
    logic signed [7:0] first_s;
    logic signed [7:0] last_s;
    logic signed [7:0] first_clamp;
    logic signed [7:0] last_clamp;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic              passed;
    logic              stepping;
    logic              paint;
    pixel_t            entry;
    logic signed [9:0] diff;
    logic [CH_W-1:0]   fade_val;
    logic              fade_we;
    logic              out_free;

    always_comb
    begin
        if (cfg_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (cfg_len_reg > LEN_W'(MAX_LEDS))
        begin
            len_eff = LEN_W'(MAX_LEDS);
        end
        else
        begin
            len_eff = cfg_len_reg;
        end
    end

    assign len_s   = signed'({2'b00, len_eff});
    assign first_s = signed'(cfg_first_reg);
    assign last_s  = signed'(cfg_last_reg);

    always_comb
    begin
        first_clamp = first_s;
        if (first_s >= len_s)
        begin
            first_clamp = len_s - 8'sd1;
        end
        if (first_s < 8'sd0)
        begin
            first_clamp = 8'sd0;
        end
        last_clamp = last_s;
        if (last_s >= len_s)
        begin
            last_clamp = len_s - 8'sd1;
        end
        if (last_s < 8'sd0)
        begin
            last_clamp = 8'sd0;
        end
    end

    assign elapsed  = now_reg - last_step_reg;
    assign due      = (elapsed >= run_interval_reg);
    assign passed   = down_reg ? (pos_reg < end_reg) : (pos_reg > end_reg);
    assign stepping = (op_reg == OP_TICK) && (mode_reg != MODE_IDLE)
                      && (run_status_reg != AS_DONE) && due;
    assign paint    = cmd.execute && stepping && (mode_reg == MODE_WIPE) && !passed;

    assign entry = rd_valid_reg ? rd_data_reg : '0;
    assign diff  = signed'({2'b00, run_val_reg}) - signed'({2'b00, entry.val});

    always_comb
    begin
        if (diff < 10'(FADE_STEP) && diff > -10'(FADE_STEP))
        begin
            fade_val = run_val_reg;
        end
        else if (diff > 10'sd0)
        begin
            fade_val = entry.val + CH_W'(FADE_STEP);
        end
        else
        begin
            fade_val = entry.val - CH_W'(FADE_STEP);
        end
    end

    assign fade_we       = cmd.fade_write && (diff != 10'sd0);
    assign mem_we        = paint || fade_we;
    assign mem_waddr     = paint ? pos_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign mem_wdata.hue = run_hue_reg;
    assign mem_wdata.sat = run_sat_reg;
    assign mem_wdata.val = paint ? run_val_reg : fade_val;

    assign out_free = !out_valid_reg || m_tready;

    assign stat.op         = op_reg;
    assign stat.fade_step  = stepping && (mode_reg == MODE_FADE);
    assign stat.fade_done  = (idx_reg == run_count_reg);
    assign stat.stream_end = (idx_reg == len_eff - LEN_W'(1));
    assign stat.out_free   = out_free;
    assign stat.changed    = changed_reg;

    always_comb
    begin
        mode_next         = mode_reg;
        run_status_next   = run_status_reg;
        last_step_next    = last_step_reg;
        pos_next          = pos_reg;
        end_next          = end_reg;
        down_next         = down_reg;
        run_hue_next      = run_hue_reg;
        run_sat_next      = run_sat_reg;
        run_val_next      = run_val_reg;
        run_interval_next = run_interval_reg;
        run_count_next    = run_count_reg;
        changed_next      = changed_reg;
        res_status_next   = res_status_reg;
        res_last_next     = res_last_reg;
        idx_next          = idx_reg;

        if (cmd.execute)
        begin
            changed_next  = 1'b0;
            res_last_next = 1'b1;
            unique case (op_reg)
                OP_WIPE, OP_FADE:
                begin
                    run_hue_next      = cfg_hue_reg;
                    run_sat_next      = cfg_sat_reg;
                    run_val_next      = cfg_val_reg;
                    run_interval_next = cfg_interval_reg;
                    last_step_next    = now_reg;
                    run_status_next   = AS_WAITING;
                    res_status_next   = AS_WAITING;
                    if (op_reg == OP_WIPE)
                    begin
                        pos_next  = first_clamp;
                        end_next  = last_clamp;
                        down_next = (first_clamp > last_clamp);
                        mode_next = MODE_WIPE;
                    end
                    else
                    begin
                        run_count_next = (cfg_count_reg > {2'b00, len_eff}) ?
                                         len_eff : cfg_count_reg[LEN_W-1:0];
                        mode_next      = MODE_FADE;
                    end
                end
                OP_TICK:
                begin
                    priority if (mode_reg == MODE_IDLE || run_status_reg == AS_DONE)
                    begin
                        res_status_next = run_status_reg;
                    end
                    else if (!due)
                    begin
                        run_status_next = AS_WAITING;
                        res_status_next = AS_WAITING;
                    end
                    else
                    begin
                        last_step_next = now_reg;
                        if (mode_reg == MODE_WIPE)
                        begin
                            if (passed)
                            begin
                                run_status_next = AS_DONE;
                                res_status_next = AS_DONE;
                            end
                            else
                            begin
                                pos_next        = down_reg ? pos_reg - 8'sd1 : pos_reg + 8'sd1;
                                run_status_next = AS_UPDATED;
                                res_status_next = AS_UPDATED;
                            end
                        end
                    end
                end
                OP_REFRESH:
                begin
                    res_status_next = res_status_reg;
                end
            endcase
        end

        if (fade_we)
        begin
            changed_next = 1'b1;
        end

        if (cmd.fade_finish)
        begin
            run_status_next = changed_reg ? AS_UPDATED : AS_DONE;
            res_status_next = changed_reg ? AS_UPDATED : AS_DONE;
            res_last_next   = !changed_reg;
        end

        if (cmd.idx_clear)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_step)
        begin
            idx_next = idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_hue_reg      <= '0;
            cfg_sat_reg      <= '0;
            cfg_val_reg      <= '0;
            cfg_first_reg    <= '0;
            cfg_last_reg     <= '0;
            cfg_count_reg    <= '0;
            cfg_interval_reg <= '0;
            cfg_len_reg      <= LEN_W'(32);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TARGET_HUE: cfg_hue_reg      <= cfg_data[HUE_W-1:0];
                CFG_TARGET_SAT: cfg_sat_reg      <= cfg_data[CH_W-1:0];
                CFG_TARGET_VAL: cfg_val_reg      <= cfg_data[CH_W-1:0];
                CFG_WIPE_FIRST: cfg_first_reg    <= cfg_data[CH_W-1:0];
                CFG_WIPE_LAST:  cfg_last_reg     <= cfg_data[CH_W-1:0];
                CFG_FADE_COUNT: cfg_count_reg    <= cfg_data[CH_W-1:0];
                CFG_INTERVAL:   cfg_interval_reg <= cfg_data[TIME_W-1:0];
                CFG_STRIP_LEN:  cfg_len_reg      <= cfg_data[LEN_W-1:0];
                default:        cfg_len_reg      <= cfg_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            op_reg  <= op_t'(s_tuser);
            now_reg <= s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            run_status_reg   <= AS_WAITING;
            last_step_reg    <= '0;
            pos_reg          <= '0;
            end_reg          <= '0;
            down_reg         <= 1'b0;
            run_hue_reg      <= '0;
            run_sat_reg      <= '0;
            run_val_reg      <= '0;
            run_interval_reg <= '0;
            run_count_reg    <= '0;
            idx_reg          <= '0;
            changed_reg      <= 1'b0;
            res_status_reg   <= AS_WAITING;
            res_last_reg     <= 1'b1;
        end
        else
        begin
            mode_reg         <= mode_next;
            run_status_reg   <= run_status_next;
            last_step_reg    <= last_step_next;
            pos_reg          <= pos_next;
            end_reg          <= end_next;
            down_reg         <= down_next;
            run_hue_reg      <= run_hue_next;
            run_sat_reg      <= run_sat_next;
            run_val_reg      <= run_val_next;
            run_interval_reg <= run_interval_next;
            run_count_reg    <= run_count_next;
            idx_reg          <= idx_next;
            changed_reg      <= changed_next;
            res_status_reg   <= res_status_next;
            res_last_reg     <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // An entry that was never written reads as black.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (cmd.mem_read)
            begin
                rd_valid_reg <= valid_reg[idx_reg[IDX_W-1:0]];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_status || cmd.emit_pixel)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_status)
        begin
            out_kind_reg   <= KIND_STATUS;
            out_status_reg <= res_status_reg;
            out_index_reg  <= '0;
            out_hue_reg    <= '0;
            out_sat_reg    <= '0;
            out_level_reg  <= '0;
            out_last_reg   <= res_last_reg;
        end
        else if (cmd.emit_pixel)
        begin
            out_kind_reg   <= KIND_PIXEL;
            out_status_reg <= AS_WAITING;
            out_index_reg  <= idx_reg;
            out_hue_reg    <= entry.hue;
            out_sat_reg    <= entry.sat;
            out_level_reg  <= GAMMA_ROM[entry.val];
            out_last_reg   <= stat.stream_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_level_reg, out_sat_reg, out_hue_reg,
                       out_index_reg, out_status_reg};

endmodule

`default_nettype wire

// ===== rtl/led_wipe_fade_animator_core.sv =====
`default_nettype none

// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   tuser: operation; tdata: now_ms
// m_*       out        m_tvalid/m_tready   tuser: kind; tdata: status and pixel; tlast
// cfg_*     in         cfg_we              register index and write data
//
// Items are taken one at a time; the sequencer walks the frame store through its single
// read port. A start or plain tick yields a status beat, a refresh streams the frame,
// and a fade step reads and rewrites each faded LED before its status and, if any LED
// changed, its stream. The frame store reads as black after reset through per-entry valid
// bits, so no clearing pass is needed. A stalled output holds the sequencer in place.

module led_wipe_fade_animator_core #(
    parameter int MAX_LEDS = lwfa_pkg::DEFAULT_MAX_LEDS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lwfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lwfa_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // now_ms [31:0]
    input  logic [lwfa_pkg::TIME_W-1:0]       s_tdata,
    // operation [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // anim_status [1:0], pixel_index [7:2], pixel_hue [16:8], pixel_saturation [24:17],
    // pixel_level [32:25], zero [39:33]
    output logic [lwfa_pkg::OUT_DATA_W-1:0]   m_tdata,
    // kind [0]
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import lwfa_pkg::*;

    lwfa_cmd_t  cmd;
    lwfa_stat_t stat;

    lwfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lwfa_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ===== sim/led_wipe_fade_animator_core_tb.sv =====
module led_wipe_fade_animator_core_tb;
    import lwfa_pkg::*;

    localparam int LEDS       = DEFAULT_MAX_LEDS;
    localparam int IDLE_LIMIT = 2000;
    localparam int ITEM_GOAL  = 405;

    typedef struct {
        logic             kind;
        logic [1:0]       status;
        logic [LEN_W-1:0] index;
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  level;
        logic             last;
    } beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TIME_W-1:0]     s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    // Register copies.
    logic [HUE_W-1:0]      reg_hue;
    logic [CH_W-1:0]       reg_sat;
    logic [CH_W-1:0]       reg_val;
    logic [7:0]            reg_first;
    logic [7:0]            reg_last;
    logic [7:0]            reg_count;
    logic [31:0]           reg_interval;
    logic [LEN_W-1:0]      reg_len;

    // Animator state.
    logic [CH_W-1:0]       gamma_lut [256];
    logic [HUE_W-1:0]      fb_hue [LEDS];
    logic [CH_W-1:0]       fb_sat [LEDS];
    logic [CH_W-1:0]       fb_val [LEDS];
    logic [1:0]            anim_mode;
    logic [1:0]            run_status;
    logic [31:0]           last_step;
    int                    wipe_pos;
    int                    wipe_stop;
    logic                  wipe_down;
    logic [HUE_W-1:0]      run_hue;
    logic [CH_W-1:0]       run_sat;
    logic [CH_W-1:0]       run_val;
    logic [31:0]           run_interval;
    int                    run_count;

    beat_t                 outbeat_q [$];
    int                    errors       = 0;
    int                    items_sent   = 0;
    int                    idle_cycles  = 0;
    int                    stall_left   = 0;
    bit                    send_idle_on = 1'b1;
    bit                    recv_idle_on = 1'b1;

    led_wipe_fade_animator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value(input logic [31:0] hi);
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    function automatic logic [31:0] pick_index(input int len);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, len + 1);
    endfunction

    function automatic int strip_leds();
        if (reg_len == 0)
            return 1;
        if (reg_len > LEDS)
            return LEDS;
        return reg_len;
    endfunction

    task automatic push_status(input logic [1:0] st, input logic last);
        outbeat_q.push_back('{kind: KIND_STATUS, status: st, index: 0, hue: 0, sat: 0,
                              level: 0, last: last});
    endtask

    task automatic stream_frame();
        int n;
        n = strip_leds();
        for (int i = 0; i < n; i++)
        begin
            outbeat_q.push_back('{kind: KIND_PIXEL, status: AS_WAITING, index: LEN_W'(i),
                                  hue: fb_hue[i], sat: fb_sat[i],
                                  level: gamma_lut[fb_val[i]], last: (i == n - 1)});
        end
    endtask

    task automatic latch_run(input logic [31:0] now);
        run_hue      = reg_hue;
        run_sat      = reg_sat;
        run_val      = reg_val;
        run_interval = reg_interval;
        last_step    = now;
        run_status   = AS_WAITING;
    endtask

    task automatic step_animator(input op_t op, input logic [31:0] now);
        int   n;
        int   first;
        int   stop;
        int   diff;
        logic changed;
        n = strip_leds();
        case (op)
            OP_REFRESH:
            begin
                stream_frame();
            end
            OP_WIPE:
            begin
                first = $signed(reg_first);
                stop  = $signed(reg_last);
                if (first >= n) first = n - 1;
                if (stop >= n)  stop = n - 1;
                if (first < 0)  first = 0;
                if (stop < 0)   stop = 0;
                latch_run(now);
                wipe_pos  = first;
                wipe_stop = stop;
                wipe_down = first > stop;
                anim_mode = MODE_WIPE;
                push_status(AS_WAITING, 1'b1);
            end
            OP_FADE:
            begin
                latch_run(now);
                run_count = (reg_count > n) ? n : reg_count;
                anim_mode = MODE_FADE;
                push_status(AS_WAITING, 1'b1);
            end
            OP_TICK:
            begin
                if (anim_mode == MODE_IDLE || run_status == AS_DONE)
                begin
                    push_status(run_status, 1'b1);
                end
                else if (now - last_step < run_interval)
                begin
                    run_status = AS_WAITING;
                    push_status(AS_WAITING, 1'b1);
                end
                else if (anim_mode == MODE_WIPE)
                begin
                    last_step = now;
                    if ((!wipe_down && wipe_pos > wipe_stop) || (wipe_down && wipe_pos < wipe_stop))
                    begin
                        run_status = AS_DONE;
                    end
                    else
                    begin
                        if (wipe_pos >= 0 && wipe_pos < LEDS)
                        begin
                            fb_hue[wipe_pos] = run_hue;
                            fb_sat[wipe_pos] = run_sat;
                            fb_val[wipe_pos] = run_val;
                        end
                        wipe_pos   = wipe_pos + (wipe_down ? -1 : 1);
                        run_status = AS_UPDATED;
                    end
                    push_status(run_status, 1'b1);
                end
                else
                begin
                    last_step = now;
                    changed   = 1'b0;
                    for (int i = 0; i < run_count && i < LEDS; i++)
                    begin
                        diff = int'(run_val) - int'(fb_val[i]);
                        if (diff != 0)
                        begin
                            fb_hue[i] = run_hue;
                            fb_sat[i] = run_sat;
                            if (diff < FADE_STEP && diff > -FADE_STEP)
                                fb_val[i] = run_val;
                            else if (diff > 0)
                                fb_val[i] = fb_val[i] + CH_W'(FADE_STEP);
                            else
                                fb_val[i] = fb_val[i] - CH_W'(FADE_STEP);
                            changed = 1'b1;
                        end
                    end
                    if (!changed)
                    begin
                        run_status = AS_DONE;
                        push_status(AS_DONE, 1'b1);
                    end
                    else
                    begin
                        run_status = AS_UPDATED;
                        push_status(AS_UPDATED, 1'b0);
                        stream_frame();
                    end
                end
            end
        endcase
    endtask

    task automatic send_item(input op_t op, input logic [31:0] now);
        int gap;
        gap = send_idle_on ? pick_gap() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= now;
        do
            @(posedge clk);
        while (!s_tready);
        step_animator(op, now);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outbeat_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [31:0] hue, sat, val, first, last, count,
                             interval, len);
        logic [31:0] vals [8];
        reg_hue      = hue[HUE_W-1:0];
        reg_sat      = sat[CH_W-1:0];
        reg_val      = val[CH_W-1:0];
        reg_first    = first[7:0];
        reg_last     = last[7:0];
        reg_count    = count[7:0];
        reg_interval = interval;
        reg_len      = len[LEN_W-1:0];
        vals[CFG_TARGET_HUE] = {23'd0, reg_hue};
        vals[CFG_TARGET_SAT] = {24'd0, reg_sat};
        vals[CFG_TARGET_VAL] = {24'd0, reg_val};
        vals[CFG_WIPE_FIRST] = {24'd0, reg_first};
        vals[CFG_WIPE_LAST]  = {24'd0, reg_last};
        vals[CFG_FADE_COUNT] = {24'd0, reg_count};
        vals[CFG_INTERVAL]   = reg_interval;
        vals[CFG_STRIP_LEN]  = {26'd0, reg_len};
        for (int i = 0; i < 8; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %0d, want %0d", $time, field, got, want);
        errors++;
    endtask

    task automatic test_reset_state();
        send_item(OP_REFRESH, 32'd0);
        send_item(OP_TICK, 32'd1);
    endtask

    task automatic test_wipe();
        drain();
        configure(32'd400, 32'd255, 32'd255, 32'h80, 32'h7F, 32'd0, 32'd0, 32'd3);
        send_item(OP_WIPE, 32'd5);
        repeat (4) send_item(OP_TICK, 32'd6);
        send_item(OP_TICK, 32'd7);
        send_item(OP_REFRESH, 32'd8);
        drain();
        configure(32'd359, 32'd0, 32'd128, 32'h7F, 32'hFF, 32'd0, 32'hFFFF_FFFF, 32'd2);
        send_item(OP_WIPE, 32'd10);
        send_item(OP_TICK, 32'd8);
        send_item(OP_TICK, 32'd9);
        send_item(OP_TICK, 32'd8);
        send_item(OP_TICK, 32'd7);
        send_item(OP_REFRESH, 32'd7);
    endtask

    task automatic test_fade();
        drain();
        configure(32'd200, 32'd100, 32'd3, 32'd0, 32'd0, 32'd255, 32'd0, 32'd63);
        send_item(OP_FADE, 32'hFFFF_FFF0);
        send_item(OP_TICK, 32'hFFFF_FFF8);
        send_item(OP_TICK, 32'h0000_0004);
        send_item(OP_REFRESH, 32'h0000_0005);
        drain();
        configure(32'd511, 32'd255, 32'd0, 32'd0, 32'd0, 32'd255, 32'd0, 32'd0);
        send_item(OP_FADE, 32'd0);
        send_item(OP_TICK, 32'd0);
        send_item(OP_REFRESH, 32'd0);
        drain();
        configure(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd32);
        send_item(OP_FADE, 32'd100);
        send_item(OP_TICK, 32'd100);
    endtask

    task automatic test_random_runs();
        logic [31:0] now;
        logic [31:0] interval;
        logic [31:0] delta;
        int          len;
        int          ticks;
        while (items_sent < ITEM_GOAL)
        begin
            drain();
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 63;
                2: len = LEDS;
                3: len = $urandom_range(0, 63);
                default: len = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 7))
                0: interval = 32'hFFFF_FFFF;
                1: interval = $urandom();
                2, 3: interval = 32'd0;
                default: interval = $urandom_range(1, 6);
            endcase
            configure(pick_value(511), pick_value(255), pick_value(255), pick_index(len),
                      pick_index(len),
                      ($urandom_range(0, 4) == 0) ? pick_value(255) : $urandom_range(0, len + 2),
                      interval, len);
            now = $urandom();
            if ($urandom_range(0, 4) == 0)
            begin
                repeat ($urandom_range(3, 8))
                    send_item(op_t'($urandom_range(0, 3)), $urandom());
            end
            else
            begin
                send_item($urandom_range(0, 1) ? OP_WIPE : OP_FADE, now);
                ticks = $urandom_range(2, (len > 8) ? 40 : 2 * len + 8);
                for (int t = 0; t < ticks; t++)
                begin
                    if (interval <= 64)
                        delta = $urandom_range(0, interval + 2);
                    else
                        delta = ($urandom_range(0, 2) == 0) ? interval : $urandom_range(0, 1000);
                    now = now + delta;
                    case ($urandom_range(0, 15))
                        0: send_item(OP_REFRESH, now);
                        1: send_item($urandom_range(0, 1) ? OP_WIPE : OP_FADE, now);
                        default: send_item(OP_TICK, now);
                    endcase
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (recv_idle_on && $urandom_range(0, 3) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = pick_gap();
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (outbeat_q.size() == 0)
            begin
                report_mismatch("unexpected transfer", m_tdata[31:0], 32'd0);
            end
            else
            begin
                want = outbeat_q.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("anim_status", m_tdata[1:0], want.status);
                if (m_tdata[7:2] !== want.index)
                    report_mismatch("pixel_index", m_tdata[7:2], want.index);
                if (m_tdata[16:8] !== want.hue)
                    report_mismatch("pixel_hue", m_tdata[16:8], want.hue);
                if (m_tdata[24:17] !== want.sat)
                    report_mismatch("pixel_saturation", m_tdata[24:17], want.sat);
                if (m_tdata[32:25] !== want.level)
                    report_mismatch("pixel_level", m_tdata[32:25], want.level);
                if (m_tdata[39:33] !== 7'd0)
                    report_mismatch("padding", m_tdata[39:33], 32'd0);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [127:0] power;
        logic [127:0] bound;
        int           k;
        // Gamma entry v counts the rounding points k + 0.5 that 255 * (v / 255)^2.2 reaches.
        k = 0;
        for (int v = 0; v < 256; v++)
        begin
            power = 128'd32;
            repeat (11) power = power * 128'(v);
            while (k < 255)
            begin
                bound = 128'd1;
                repeat (5) bound = bound * 128'(2 * k + 1);
                repeat (6) bound = bound * 128'd255;
                if (power < bound)
                    break;
                k++;
            end
            gamma_lut[v] = CH_W'(k);
        end
        for (int i = 0; i < LEDS; i++)
        begin
            fb_hue[i] = '0;
            fb_sat[i] = '0;
            fb_val[i] = '0;
        end
        reg_hue      = '0;
        reg_sat      = '0;
        reg_val      = '0;
        reg_first    = '0;
        reg_last     = '0;
        reg_count    = '0;
        reg_interval = '0;
        reg_len      = LEN_W'(32);
        anim_mode    = MODE_IDLE;
        run_status   = AS_WAITING;
        last_step    = '0;
        wipe_pos     = 0;
        wipe_stop    = 0;
        wipe_down    = 1'b0;
        run_hue      = '0;
        run_sat      = '0;
        run_val      = '0;
        run_interval = '0;
        run_count    = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_wipe();
        test_fade();
        test_random_runs();

        drain();
        repeat (64) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lwfa_pkg.sv
rtl/lwfa_ctrl.sv
rtl/lwfa_datapath.sv
rtl/led_wipe_fade_animator_core.sv
sim/led_wipe_fade_animator_core_tb.sv
